[hdl/tpss_pkg.sv]
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared constants, widths and types for the transport stream sync sniffer.
// ----------------------------------------------------------------------------
package tpss_pkg;

   // number of consecutive sync bytes that must line up
   localparam int SNIFF_PACKETS   = 5;

   localparam int TS_STRIDE       = 188;
   localparam int M2TS_STRIDE     = 192;
   localparam int MAX_SYNC_POS    = M2TS_STRIDE - 1;
   localparam int PROBE_DEPTH     = MAX_SYNC_POS + SNIFF_PACKETS * M2TS_STRIDE;
   localparam int MIN_BYTES       = SNIFF_PACKETS * TS_STRIDE;

   // distance from the first to the last sync byte of a candidate
   localparam int SPAN_SHORT      = (SNIFF_PACKETS - 1) * TS_STRIDE;
   localparam int SPAN_LONG       = (SNIFF_PACKETS - 1) * M2TS_STRIDE;

   localparam int ADDR_W          = $clog2(PROBE_DEPTH);
   localparam int COUNT_W         = $clog2(PROBE_DEPTH + 1);
   localparam int IDX_W           = $clog2(SNIFF_PACKETS);

   localparam logic [7:0] SYNC_BYTE = 8'h47;

   localparam logic [1:0] STATUS_FOUND = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

[hdl/tpss_probe_ram.sv]
// ----------------------------------------------------------------------------
// tpss_probe_ram
// Single-port-write, single-port-read byte store with registered read data.
// ----------------------------------------------------------------------------
module tpss_probe_ram (
   input  logic               clock,
   input  logic               wr_en,
   input  tpss_pkg::addr_type wr_addr,
   input  logic [7:0]         wr_data,
   input  logic               rd_en,
   input  tpss_pkg::addr_type rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [tpss_pkg::PROBE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ts_packet_sync_sniffer.sv]
// Results: a too-short result is ready the cycle after the last byte transfer.
// Otherwise each (offset, stride) candidate is tried in S_CAND, and its sync
// bytes are read and compared one at a time in S_READ and S_CHECK through the
// single RAM read port, for at most 384 candidates. The input stalls in search.
// Throughput: one byte per cycle in fill; a pending result stalls a last byte.
// Reset: synchronous, active high; clears the byte count and control state.
// ----------------------------------------------------------------------------
// ts_packet_sync_sniffer
// Stores the opening bytes of a transport stream segment and finds the first
// offset and stride (188 or 192) at which sync bytes line up.
// ----------------------------------------------------------------------------
module ts_packet_sync_sniffer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_first_sync,
   output logic       rsp_long_packets
);

   typedef enum logic [3:0] {
      S_FILL  = 4'b0001,
      S_CAND  = 4'b0010,
      S_READ  = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   localparam int COUNT_W = tpss_pkg::COUNT_W;
   localparam int ADDR_W  = tpss_pkg::ADDR_W;
   localparam int IDX_W   = tpss_pkg::IDX_W;

   state_type              state_ff, state_in;
   tpss_pkg::count_type    byte_count_ff, byte_count_in;
   logic [7:0]             off_ff, off_in;
   logic                   long_ff, long_in;
   tpss_pkg::addr_type     pos_ff, pos_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [7:0]             rsp_offset_ff, rsp_offset_in;
   logic                   rsp_long_ff, rsp_long_in;

   logic                   req_xfer;
   logic                   count_full;
   tpss_pkg::count_type    count_next;
   tpss_pkg::count_type    last_pos;
   tpss_pkg::addr_type     stride;
   logic                   wr_en;
   logic                   rd_en;
   logic [7:0]             rd_data;
   logic                   cand_fail;
   logic                   cand_found;

   assign req_stall  = (state_ff != S_FILL) || (rsp_valid_ff && req_last_byte);
   assign req_xfer   = req_valid && !req_stall;
   assign count_full = (byte_count_ff == COUNT_W'(tpss_pkg::PROBE_DEPTH));
   assign count_next = count_full ? byte_count_ff : byte_count_ff + COUNT_W'(1);
   assign wr_en      = req_xfer && !count_full;
   assign rd_en      = (state_ff == S_READ);
   assign stride     = long_ff ? ADDR_W'(tpss_pkg::M2TS_STRIDE)
                               : ADDR_W'(tpss_pkg::TS_STRIDE);
   assign last_pos   = COUNT_W'(off_ff) + (long_ff ? COUNT_W'(tpss_pkg::SPAN_LONG)
                                                   : COUNT_W'(tpss_pkg::SPAN_SHORT));

   tpss_probe_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (byte_count_ff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      off_in        = off_ff;
      long_in       = long_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_long_in   = rsp_long_ff;
      cand_fail     = 1'b0;
      cand_found    = 1'b0;

      unique case (state_ff)
         S_FILL: begin
            if (req_xfer) begin
               byte_count_in = count_next;
               if (req_last_byte) begin
                  if (count_next < COUNT_W'(tpss_pkg::MIN_BYTES)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = tpss_pkg::STATUS_SHORT;
                     rsp_offset_in = 8'd0;
                     rsp_long_in   = 1'b0;
                     byte_count_in = '0;
                  end else begin
                     off_in   = 8'd0;
                     long_in  = 1'b0;
                     state_in = S_CAND;
                  end
               end
            end
         end
         S_CAND: begin
            // the whole candidate must lie inside the stored bytes
            if (last_pos < byte_count_ff) begin
               pos_in   = ADDR_W'(off_ff);
               idx_in   = '0;
               state_in = S_READ;
            end else begin
               cand_fail = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rd_data != tpss_pkg::SYNC_BYTE) begin
               cand_fail = 1'b1;
            end else if (idx_ff == IDX_W'(tpss_pkg::SNIFF_PACKETS - 1)) begin
               cand_found = 1'b1;
            end else begin
               pos_in   = pos_ff + stride;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_FILL;
         end
      endcase

      if (cand_found) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = tpss_pkg::STATUS_FOUND;
         rsp_offset_in = off_ff;
         rsp_long_in   = long_ff;
         byte_count_in = '0;
         state_in      = S_FILL;
      end else if (cand_fail) begin
         // stride 188 first, then 192, then the next offset
         if (!long_ff) begin
            long_in  = 1'b1;
            state_in = S_CAND;
         end else if (off_ff == 8'(tpss_pkg::MAX_SYNC_POS)) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = tpss_pkg::STATUS_NONE;
            rsp_offset_in = 8'd0;
            rsp_long_in   = 1'b0;
            byte_count_in = '0;
            state_in      = S_FILL;
         end else begin
            off_in   = off_ff + 8'd1;
            long_in  = 1'b0;
            state_in = S_CAND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         byte_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      long_ff       <= long_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_long_ff   <= rsp_long_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_first_sync   = rsp_offset_ff;
   assign rsp_long_packets = rsp_long_ff;

`ifndef SYNTHESIS
   // every compare sees data fetched by a read in the cycle before
   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_READ))
      else $error("compare without a preceding ram read");

   // reads stay inside the bytes stored for this segment
   a_read_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (COUNT_W'(pos_ff) < byte_count_ff))
      else $error("probe ram read beyond stored bytes");

   // no result is pending while a search runs
   a_no_pending_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FILL) |-> !rsp_valid_ff)
      else $error("result pending during offset search");

   // the byte count is frozen while searching
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != S_FILL) && (state_in != S_FILL)) |=> $stable(byte_count_ff))
      else $error("byte count changed during search");

   // a sync byte index never passes the packet count
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (int'(idx_ff) < tpss_pkg::SNIFF_PACKETS))
      else $error("sync byte index out of range");
`endif

endmodule
